@@ sv/pdid_pkg.sv @@
// ----------------------------------------------------------------------------
// pdid_pkg
// Shared types and constants of the pattern de-duplication id assigner.
// ----------------------------------------------------------------------------
package pdid_pkg;

  localparam int DEF_MAX_PATTERNS = 256;
  localparam int DEF_MAX_LEN      = 64;

  // Result word: id, was_new, table_full, too_long, unique_count, signature_count
  localparam int OUT_W = 40;

  // Input operation codes (carried on in_tuser)
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LEN_CHK,
    S_BYTE_RD,
    S_BYTE_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic take_byte;   // append byte of the accepted transaction
    logic clear;       // empty table, zero counters
    logic scan_init;   // last byte accepted: restart search at entry 0
    logic len_rd;      // read stored length of current entry
    logic next_entry;  // advance to the next stored entry
    logic byte_start;  // lengths agree: compare from byte 0
    logic byte_rd;     // read one stored byte and one pattern byte
    logic next_byte;   // advance byte position
    logic hit;         // all bytes matched
    logic finish;      // load the result register and commit
  } cmd_t;

  typedef struct packed {
    logic ovf;        // current pattern ran past the maximum length
    logic scan_end;   // every stored entry has been visited
    logic len_eq;     // stored length equals pattern length
    logic byte_eq;    // compared bytes agree
    logic byte_last;  // compared byte was the final one
    logic out_free;   // result register can take a new result
  } stat_t;

endpackage

@@ sv/pdid_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdid_ctrl
// Sequencer: accepts bytes and clears, walks the stored entries for a match.
// ----------------------------------------------------------------------------
module pdid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tuser,
  input  logic            in_tlast,
  output logic            in_tready,
  input  pdid_pkg::stat_t stat,
  output pdid_pkg::cmd_t  cmd
);
  import pdid_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tuser == OP_BYTE && in_tlast) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        state_nxt = (stat.ovf || stat.scan_end) ? S_FINISH : S_LEN_CHK;
      end
      S_LEN_CHK: begin
        state_nxt = stat.len_eq ? S_BYTE_RD : S_SCAN;
      end
      S_BYTE_RD: begin
        state_nxt = S_BYTE_CHK;
      end
      S_BYTE_CHK: begin
        if (!stat.byte_eq) begin
          state_nxt = S_SCAN;
        end else if (stat.byte_last) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_BYTE_RD;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd.take_byte = in_tvalid && in_tuser == OP_BYTE;
        cmd.clear     = in_tvalid && in_tuser == OP_CLEAR;
        cmd.scan_init = in_tvalid && in_tuser == OP_BYTE && in_tlast;
      end
      S_SCAN: begin
        cmd.len_rd = !stat.ovf && !stat.scan_end;
      end
      S_LEN_CHK: begin
        if (stat.len_eq) begin
          cmd.byte_start = 1'b1;
        end else begin
          cmd.next_entry = 1'b1;
        end
      end
      S_BYTE_RD: begin
        cmd.byte_rd = 1'b1;
      end
      S_BYTE_CHK: begin
        if (!stat.byte_eq) begin
          cmd.next_entry = 1'b1;
        end else if (stat.byte_last) begin
          cmd.hit = 1'b1;
        end else begin
          cmd.next_byte = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ sv/pdid_dpath.sv @@
// ----------------------------------------------------------------------------
// pdid_dpath
// Pattern buffer, entry store, length table, counters and result register.
// ----------------------------------------------------------------------------
module pdid_dpath #(
  parameter int MAX_PATTERNS = pdid_pkg::DEF_MAX_PATTERNS,
  parameter int MAX_LEN      = pdid_pkg::DEF_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pdid_pkg::cmd_t             cmd,
  output pdid_pkg::stat_t            stat,
  input  logic [7:0]                 in_byte,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [pdid_pkg::OUT_W-1:0] out_tdata
);
  import pdid_pkg::*;

  localparam int CW  = $clog2(MAX_PATTERNS + 1);            // entry count
  localparam int KW  = $clog2(MAX_PATTERNS);                // entry index
  localparam int LCW = $clog2(MAX_LEN + 1);                 // byte count
  localparam int JW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1; // byte index
  localparam int AW  = $clog2(MAX_PATTERNS * MAX_LEN);      // store address

  logic [7:0]     cur_mem   [0:MAX_LEN-1];
  logic [7:0]     store_mem [0:MAX_PATTERNS*MAX_LEN-1];
  logic [LCW-1:0] len_mem   [0:MAX_PATTERNS-1];

  logic [LCW-1:0] cur_len_r, cur_len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  stored_r, stored_nxt;
  logic [15:0]    seen_r, seen_nxt;
  logic [AW-1:0]  wr_base_r, wr_base_nxt;
  logic           hit_r, hit_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [AW-1:0]  rd_base_r, rd_base_nxt;
  logic [LCW-1:0] j_r, j_nxt;
  logic [7:0]     id_r, id_nxt;
  logic           new_r, new_nxt;
  logic           full_r, full_nxt;
  logic           long_r, long_nxt;
  logic [LCW-1:0] len_q_r;
  logic [7:0]     st_q_r;
  logic [7:0]     cur_q_r;

  logic           room;
  logic           tbl_full;
  logic           store_new;
  logic [LCW-1:0] j_inc;

  assign room      = cur_len_r < LCW'(MAX_LEN);
  assign tbl_full  = stored_r == CW'(MAX_PATTERNS);
  assign store_new = cmd.finish && !hit_r && !ovf_r && !tbl_full;
  assign j_inc     = j_r + LCW'(1);

  assign stat.ovf       = ovf_r;
  assign stat.scan_end  = k_r == stored_r;
  assign stat.len_eq    = len_q_r == cur_len_r;
  assign stat.byte_eq   = st_q_r == cur_q_r;
  assign stat.byte_last = j_inc == cur_len_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  // Bytes land both in the pattern buffer and in the free slot, so a new
  // entry needs no copy once the search misses.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && room) begin
      cur_mem[cur_len_r[JW-1:0]] <= in_byte;
    end
    if (cmd.byte_rd) begin
      cur_q_r <= cur_mem[j_r[JW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && room && !tbl_full) begin
      store_mem[wr_base_r + AW'(cur_len_r)] <= in_byte;
    end
    if (cmd.byte_rd) begin
      st_q_r <= store_mem[rd_base_r + AW'(j_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (store_new) begin
      len_mem[stored_r[KW-1:0]] <= cur_len_r;
    end
    if (cmd.len_rd) begin
      len_q_r <= len_mem[k_r[KW-1:0]];
    end
  end

  always_comb begin
    cur_len_nxt   = cur_len_r;
    ovf_nxt       = ovf_r;
    stored_nxt    = stored_r;
    seen_nxt      = seen_r;
    wr_base_nxt   = wr_base_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    k_nxt         = k_r;
    rd_base_nxt   = rd_base_r;
    j_nxt         = j_r;
    id_nxt        = id_r;
    new_nxt       = new_r;
    full_nxt      = full_r;
    long_nxt      = long_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.take_byte) begin
      if (room) begin
        cur_len_nxt = cur_len_r + LCW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.scan_init) begin
      k_nxt       = '0;
      rd_base_nxt = '0;
      hit_nxt     = 1'b0;
    end
    if (cmd.next_entry) begin
      k_nxt       = k_r + CW'(1);
      rd_base_nxt = rd_base_r + AW'(MAX_LEN);
    end
    if (cmd.byte_start) begin
      j_nxt = '0;
    end
    if (cmd.next_byte) begin
      j_nxt = j_inc;
    end
    if (cmd.hit) begin
      hit_nxt = 1'b1;
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      id_nxt        = '0;
      new_nxt       = 1'b0;
      full_nxt      = 1'b0;
      long_nxt      = 1'b0;
      if (seen_r != 16'hFFFF) begin
        seen_nxt = seen_r + 16'd1;
      end
      if (ovf_r) begin
        long_nxt = 1'b1;
      end else if (hit_r) begin
        id_nxt = 8'(k_r);
      end else if (tbl_full) begin
        full_nxt = 1'b1;
      end else begin
        id_nxt      = 8'(stored_r);
        new_nxt     = 1'b1;
        stored_nxt  = stored_r + CW'(1);
        wr_base_nxt = wr_base_r + AW'(MAX_LEN);
      end
      cur_len_nxt = '0;
      ovf_nxt     = 1'b0;
    end

    if (cmd.clear) begin
      stored_nxt  = '0;
      seen_nxt    = '0;
      wr_base_nxt = '0;
      cur_len_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r   <= '0;
      ovf_r       <= 1'b0;
      stored_r    <= '0;
      seen_r      <= '0;
      wr_base_r   <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_len_r   <= cur_len_nxt;
      ovf_r       <= ovf_nxt;
      stored_r    <= stored_nxt;
      seen_r      <= seen_nxt;
      wr_base_r   <= wr_base_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    rd_base_r <= rd_base_nxt;
    j_r       <= j_nxt;
    id_r      <= id_nxt;
    new_r     <= new_nxt;
    full_r    <= full_nxt;
    long_r    <= long_nxt;
  end

  // Counts shown with the result are those after this pattern
  logic [8:0]  uniq_r;
  logic [15:0] sig_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      uniq_r <= 9'(stored_nxt);
      sig_r  <= seen_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, sig_r, uniq_r, long_r, full_r, new_r, id_r};

endmodule

@@ sv/pattern_dedup_id_assigner.sv @@
// ----------------------------------------------------------------------------
// pattern_dedup_id_assigner
// Assigns dense ids to unique byte patterns and reports repeats.
// ----------------------------------------------------------------------------
// Patterns arrive one byte per transaction with tlast on the final byte;
// in_tuser high clears the table and both counters instead. A byte that is
// not a final byte, and a clear, leave the input ready. A final byte then
// holds the input while the stored entries are walked in order: for each
// entry the stored length is read and checked, and for an entry of equal
// length each stored byte is read and compared against the pattern byte;
// the end of the table is detected when nothing matches (an overlong
// pattern skips the walk and takes only this check), and then the result
// is committed, held for as long as the previous result still waits on the
// output register. The length table and the entry store are read through
// registers. Bytes for the next pattern are taken while a result waits on
// the output register. All tables start undefined and need no clearing
// pass after reset.
module pattern_dedup_id_assigner #(
  parameter int MAX_PATTERNS = pdid_pkg::DEF_MAX_PATTERNS,
  parameter int MAX_LEN      = pdid_pkg::DEF_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] pattern_byte
  input  logic                       in_tuser,   // operation
  input  logic                       in_tlast,   // last_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [7:0] pattern_id, [8] was_new, [9] table_full, [10] too_long,
  // [19:11] unique_count, [35:20] signature_count, [39:36] zero
  output logic [pdid_pkg::OUT_W-1:0] out_tdata
);
  import pdid_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pdid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdid_dpath #(
    .MAX_PATTERNS (MAX_PATTERNS),
    .MAX_LEN      (MAX_LEN)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // A final byte starts a search, so the input stalls after it is accepted
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_BYTE && in_tlast |=> !in_tready)
    else $error("input not stalled after final byte");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tdata[10:8]))
    else $error("result flags not exclusive");

  a_new_id_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[7:0] == 8'(out_tdata[19:11] - 9'd1))
    else $error("new entry id does not follow unique count");

  a_rejected_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9] || out_tdata[10]) |-> out_tdata[7:0] == 8'd0)
    else $error("rejected pattern carries nonzero id");

endmodule
